@@ rtl/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg: shared types, widths and helpers
// Fixed-point widths of the rotation matrix to quaternion pipeline, the lane
// record of the square root pipe and the digit step of the root.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int FRAC_BITS = 14;            // fraction bits, 1.0 = 1 << FRAC_BITS
	localparam int IN_W      = 16;            // matrix element width
	localparam int OUT_W     = 16;            // signed quaternion component width
	localparam int W_W       = 15;            // unsigned scalar part width
	localparam int LANES     = 4;             // w, x, y, z
	localparam int STEPS     = 4;             // root digits resolved per stage

	// largest diagonal sum: 1.0 plus three most negative elements negated
	localparam int SUM_MAX   = (1 << FRAC_BITS) + 3 * (1 << (IN_W - 1));
	localparam int SUM_W     = $clog2(SUM_MAX + 1) + 1;      // signed sum
	localparam int MAG_IN_W  = SUM_W - 1;                     // clamped sum
	localparam int RAD_BITS  = MAG_IN_W + FRAC_BITS;
	localparam int ROOT_W    = (((RAD_BITS + 1) / 2) + STEPS - 1) / STEPS * STEPS;
	localparam int RAD_W     = 2 * ROOT_W;
	localparam int REM_W     = ROOT_W + 2;
	localparam int NSTG      = ROOT_W / STEPS;                // root stages
	localparam int CMP_W     = (ROOT_W > W_W) ? ROOT_W : W_W;

	localparam logic [W_W-1:0] MAG_MAX = '1;

	typedef enum logic [1:0] {
		LANE_W = 2'd0,
		LANE_X = 2'd1,
		LANE_Y = 2'd2,
		LANE_Z = 2'd3
	} lane_idx_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;   // radicand digits still to bring down, MSB first
		logic [REM_W-1:0]  rem;   // partial remainder
		logic [ROOT_W-1:0] root;  // partial root
	} lane_t;

	typedef struct packed {
		lane_t [LANES-1:0] lane;
		logic  [2:0]       neg;   // x, y, z take a minus sign (bit 0 = x)
	} sq_t;

	// one restoring digit step of the integer square root
	function automatic lane_t sqrt_step(lane_t a);
		lane_t            b;
		logic [REM_W-1:0] r;
		logic [REM_W-1:0] t;
		r = {a.rem[REM_W-3:0], a.rad[RAD_W-1 -: 2]};
		t = {a.root, 2'b01};
		b.rad = {a.rad[RAD_W-3:0], 2'b00};
		if (r >= t) begin
			b.rem  = r - t;
			b.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			b.rem  = r;
			b.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return b;
	endfunction

	// halve the root and saturate to the 15-bit magnitude range
	function automatic logic [W_W-1:0] half_sat(logic [ROOT_W-1:0] root);
		logic [CMP_W-1:0] m;
		m = CMP_W'(root >> 1);
		if (m > CMP_W'(MAG_MAX)) begin
			return MAG_MAX;
		end
		return m[W_W-1:0];
	endfunction

endpackage

@@ rtl/rmq_front.sv @@
// ----------------------------------------------------------------------------
// rmq_front: diagonal sums and signs
// Forms the four diagonal sums, clamps them at zero, scales them into root
// radicands and takes the signs of the three off-diagonal differences.
// ----------------------------------------------------------------------------
module rmq_front
	import rmq_pkg::*;
(
	input  logic signed [IN_W-1:0] r00,
	input  logic signed [IN_W-1:0] r01,
	input  logic signed [IN_W-1:0] r02,
	input  logic signed [IN_W-1:0] r10,
	input  logic signed [IN_W-1:0] r11,
	input  logic signed [IN_W-1:0] r12,
	input  logic signed [IN_W-1:0] r20,
	input  logic signed [IN_W-1:0] r21,
	input  logic signed [IN_W-1:0] r22,
	output sq_t                    sq
);

	logic signed [SUM_W-1:0] one;
	logic signed [SUM_W-1:0] a00;
	logic signed [SUM_W-1:0] a11;
	logic signed [SUM_W-1:0] a22;
	logic signed [SUM_W-1:0] sum [LANES];
	logic signed [IN_W:0]    dx;
	logic signed [IN_W:0]    dy;
	logic signed [IN_W:0]    dz;

	assign one = SUM_W'(1) << FRAC_BITS;
	assign a00 = SUM_W'(r00);
	assign a11 = SUM_W'(r11);
	assign a22 = SUM_W'(r22);

	assign sum[LANE_W] = one + a00 + a11 + a22;
	assign sum[LANE_X] = one + a00 - a11 - a22;
	assign sum[LANE_Y] = one - a00 + a11 - a22;
	assign sum[LANE_Z] = one - a00 - a11 + a22;

	assign dx = (IN_W+1)'(r21) - (IN_W+1)'(r12);
	assign dy = (IN_W+1)'(r02) - (IN_W+1)'(r20);
	assign dz = (IN_W+1)'(r10) - (IN_W+1)'(r01);

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			// negative sums clamp to zero
			if (sum[i][SUM_W-1]) begin
				sq.lane[i].rad = '0;
			end else begin
				sq.lane[i].rad = RAD_W'({sum[i][MAG_IN_W-1:0], {FRAC_BITS{1'b0}}});
			end
			sq.lane[i].rem  = '0;
			sq.lane[i].root = '0;
		end
		sq.neg = {dz[IN_W], dy[IN_W], dx[IN_W]};
	end

endmodule

@@ rtl/rmq_root_stage.sv @@
// ----------------------------------------------------------------------------
// rmq_root_stage: square root digit stage
// Resolves STEPS root digits on each of the four lanes; signs pass through.
// ----------------------------------------------------------------------------
module rmq_root_stage
	import rmq_pkg::*;
(
	input  sq_t d,
	output sq_t q
);

	always_comb begin
		q = d;
		for (int i = 0; i < LANES; i++) begin
			for (int k = 0; k < STEPS; k++) begin
				q.lane[i] = sqrt_step(q.lane[i]);
			end
		end
	end

endmodule

@@ rtl/rotation_matrix_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: 3x3 rotation matrix to unit quaternion
// Q2.14 matrix in; Q2.14 signed x, y, z and unsigned Q1.14 w out; pipelined digit-by-digit roots.
// ----------------------------------------------------------------------------
//
//  channel  handshake                  payload
//  -------  -------------------------  ---------------------------------------
//  in       in_valid / in_stall        r00 r01 r02 r10 r11 r12 r20 r21 r22
//  out      out_valid / out_stall      quat_w quat_x quat_y quat_z
//
//  One beat per cycle in and out while out_stall does not hold the pipe. The
//  pipe has one stage of diagonal sums, NSTG stages of four root digits
//  each, and the output register.
//  Reset clears only the valid bits; payload registers are not reset.
//  A stage holds while its successor is full and stalled, so an output stall
//  holds every full stage back to the first bubble in that same cycle;
//  bubbles still close up.
//
module rotation_matrix_to_quaternion
	import rmq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [IN_W-1:0]  r00,
	input  logic signed [IN_W-1:0]  r01,
	input  logic signed [IN_W-1:0]  r02,
	input  logic signed [IN_W-1:0]  r10,
	input  logic signed [IN_W-1:0]  r11,
	input  logic signed [IN_W-1:0]  r12,
	input  logic signed [IN_W-1:0]  r20,
	input  logic signed [IN_W-1:0]  r21,
	input  logic signed [IN_W-1:0]  r22,

	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [W_W-1:0]          quat_w,
	output logic signed [OUT_W-1:0] quat_x,
	output logic signed [OUT_W-1:0] quat_y,
	output logic signed [OUT_W-1:0] quat_z
);

	// Pipe slot 0 is stage 1 (sums); slots 1..NSTG are the root stages.
	sq_t  front;
	sq_t  lanes_s   [NSTG+1];
	logic valid_s   [NSTG+1];
	sq_t  stage_out [NSTG];
	logic adv       [NSTG+2];   // slot may load this cycle; last entry is the output

	rmq_front u_front (
		.r00 (r00),
		.r01 (r01),
		.r02 (r02),
		.r10 (r10),
		.r11 (r11),
		.r12 (r12),
		.r20 (r20),
		.r21 (r21),
		.r22 (r22),
		.sq  (front)
	);

	for (genvar g = 0; g < NSTG; g++) begin : g_root
		rmq_root_stage u_stage (
			.d (lanes_s[g]),
			.q (stage_out[g])
		);
	end

	// A slot loads when it is empty or its content moves on in the same cycle.
	always_comb begin
		adv[NSTG+1] = !out_valid || !out_stall;
		for (int k = NSTG; k >= 0; k--) begin
			adv[k] = !valid_s[k] || adv[k+1];
		end
	end

	assign in_stall = !adv[0];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NSTG; k++) begin
				valid_s[k] <= 1'b0;
			end
			out_valid <= 1'b0;
		end else begin
			if (adv[0]) begin
				valid_s[0] <= in_valid;
			end
			for (int k = 1; k <= NSTG; k++) begin
				if (adv[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
			if (adv[NSTG+1]) begin
				out_valid <= valid_s[NSTG];
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			lanes_s[0] <= front;
		end
		for (int k = 1; k <= NSTG; k++) begin
			if (adv[k]) begin
				lanes_s[k] <= stage_out[k-1];
			end
		end
		if (adv[NSTG+1]) begin
			quat_w <= half_sat(lanes_s[NSTG].lane[LANE_W].root);
			// no negative zero: negating a zero magnitude stays zero
			quat_x <= lanes_s[NSTG].neg[0]
				? -OUT_W'(half_sat(lanes_s[NSTG].lane[LANE_X].root))
				:  OUT_W'(half_sat(lanes_s[NSTG].lane[LANE_X].root));
			quat_y <= lanes_s[NSTG].neg[1]
				? -OUT_W'(half_sat(lanes_s[NSTG].lane[LANE_Y].root))
				:  OUT_W'(half_sat(lanes_s[NSTG].lane[LANE_Y].root));
			quat_z <= lanes_s[NSTG].neg[2]
				? -OUT_W'(half_sat(lanes_s[NSTG].lane[LANE_Z].root))
				:  OUT_W'(half_sat(lanes_s[NSTG].lane[LANE_Z].root));
		end
	end

endmodule
